/* rtl/core/mnr_pkg.sv */
`default_nettype none
package mnr_pkg;

  localparam int IN_WIDTH  = 16;
  localparam int PW        = 2 * IN_WIDTH;
  localparam int DW        = 2 * IN_WIDTH + 1;
  localparam int QW        = DW + 1;
  localparam int CW        = $clog2(DW + 1);
  localparam int WHOLE_W   = 17;
  localparam int NUMER_W   = 32;
  localparam int DENOM_W   = 17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_W,
    S_GCD,
    S_DIV_N,
    S_DIV_D,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 go;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] quo;
    logic signed [DW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/mnr_in_if.sv */
`default_nettype none
interface mnr_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mnr_pkg::IN_WIDTH-1:0] whole_in;
  logic signed [mnr_pkg::IN_WIDTH-1:0] numer_in;
  logic signed [mnr_pkg::IN_WIDTH-1:0] denom_in;

  modport source (output valid, output whole_in, output numer_in, output denom_in,
                  input ready);
  modport sink   (input valid, input whole_in, input numer_in, input denom_in,
                  output ready);
endinterface
`default_nettype wire

/* rtl/core/mnr_out_if.sv */
`default_nettype none
interface mnr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mnr_pkg::WHOLE_W-1:0] whole_out;
  logic signed [mnr_pkg::NUMER_W-1:0] numer_out;
  logic signed [mnr_pkg::DENOM_W-1:0] denom_out;
  logic                               div_zero;

  modport source (output valid, output whole_out, output numer_out, output denom_out,
                  output div_zero, input ready);
  modport sink   (input valid, input whole_out, input numer_out, input denom_out,
                  input div_zero, output ready);
endinterface
`default_nettype wire

/* rtl/core/mnr_div.sv */
`default_nettype none
module mnr_div (
  input  wire                clk,
  input  wire                rst_n,
  input  mnr_pkg::div_req_t  req,
  output mnr_pkg::div_rsp_t  rsp
);

  logic                        run_r;
  logic                        done_r;
  logic [mnr_pkg::CW-1:0]      cnt_r;
  logic [mnr_pkg::DW-1:0]      rem_r;
  logic [mnr_pkg::DW-1:0]      quo_r;
  logic [mnr_pkg::DW-1:0]      bm_r;
  logic                        qneg_r;
  logic                        rneg_r;

  logic [mnr_pkg::DW-1:0]      trial;
  logic [mnr_pkg::DW-1:0]      diff;
  logic                        fits;
  logic [mnr_pkg::DW-1:0]      am;
  logic [mnr_pkg::DW-1:0]      bm;
  logic                        start;
  logic signed [mnr_pkg::QW-1:0] quo_ext;

  assign start = req.go && !run_r;
  assign am    = req.a[mnr_pkg::DW-1] ? mnr_pkg::DW'(-req.a) : mnr_pkg::DW'(req.a);
  assign bm    = req.b[mnr_pkg::DW-1] ? mnr_pkg::DW'(-req.b) : mnr_pkg::DW'(req.b);
  assign trial = {rem_r[mnr_pkg::DW-2:0], quo_r[mnr_pkg::DW-1]};
  assign fits  = trial >= bm_r;
  assign diff  = trial - bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == mnr_pkg::CW'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // restoring divide on magnitudes, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= am;
      bm_r   <= bm;
      cnt_r  <= mnr_pkg::CW'(mnr_pkg::DW);
      qneg_r <= req.a[mnr_pkg::DW-1] ^ req.b[mnr_pkg::DW-1];
      rneg_r <= req.a[mnr_pkg::DW-1];
    end else if (run_r) begin
      rem_r <= fits ? diff : trial;
      quo_r <= {quo_r[mnr_pkg::DW-2:0], fits};
      cnt_r <= cnt_r - mnr_pkg::CW'(1);
    end
  end

  assign quo_ext  = {1'b0, quo_r};
  assign rsp.done = done_r;
  assign rsp.quo  = qneg_r ? -quo_ext : quo_ext;
  assign rsp.rem  = rneg_r ? -$signed(rem_r) : $signed(rem_r);

endmodule
`default_nettype wire

/* rtl/core/mixed_number_reduce.sv */
// Reduces one mixed number per word. The block forms whole*den + num, then in
// mixed mode divides by the denominator for the whole part and remainder, and
// in improper mode keeps the total as numerator; the fraction is then reduced
// by the signed Euclid recursion and two divisions by the GCD. All divisions
// and remainders run on one shared restoring divider, one quotient bit a
// cycle. A zero denominator skips the arithmetic and gives a div_zero word.
// in_word.ready is high only while no word is being worked on; the finished
// word waits in an output register, so the next word may be taken meanwhile.
// The mode bit mode_r is written through cfg_we.
`default_nettype none
module mixed_number_reduce (
  input  wire       clk,
  input  wire       rst_n,
  mnr_in_if.sink    in_word,
  mnr_out_if.source out_word,
  input  wire       cfg_we,
  input  wire       cfg_wdata
);

  mnr_pkg::state_t state_r, state_nxt;

  logic mode_r;
  logic go_r, go_nxt;
  logic zero_r, zero_nxt;

  logic signed [mnr_pkg::IN_WIDTH-1:0] whole_r, whole_nxt;
  logic signed [mnr_pkg::IN_WIDTH-1:0] num_r, num_nxt;
  logic signed [mnr_pkg::IN_WIDTH-1:0] den_r, den_nxt;
  logic signed [mnr_pkg::DW-1:0]       total_r, total_nxt;
  logic signed [mnr_pkg::QW-1:0]       w_r, w_nxt;
  logic signed [mnr_pkg::DW-1:0]       n_r, n_nxt;
  logic signed [mnr_pkg::DW-1:0]       ga_r, ga_nxt;
  logic signed [mnr_pkg::DW-1:0]       gb_r, gb_nxt;
  logic signed [mnr_pkg::QW-1:0]       nq_r, nq_nxt;
  logic signed [mnr_pkg::DENOM_W-1:0]  dq_r, dq_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [mnr_pkg::WHOLE_W-1:0] out_whole_r, out_whole_nxt;
  logic signed [mnr_pkg::NUMER_W-1:0] out_numer_r, out_numer_nxt;
  logic signed [mnr_pkg::DENOM_W-1:0] out_denom_r, out_denom_nxt;
  logic                               out_zero_r, out_zero_nxt;

  logic signed [mnr_pkg::PW-1:0] prod;
  mnr_pkg::div_req_t div_req;
  mnr_pkg::div_rsp_t div_rsp;

  mnr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign prod = mnr_pkg::PW'(whole_r) * mnr_pkg::PW'(den_r);

  always_comb begin
    div_req.go = go_r;
    unique case (state_r)
      mnr_pkg::S_DIV_W: begin
        div_req.a = total_r;
        div_req.b = mnr_pkg::DW'(den_r);
      end
      mnr_pkg::S_DIV_N: begin
        div_req.a = n_r;
        div_req.b = ga_r;
      end
      mnr_pkg::S_DIV_D: begin
        div_req.a = mnr_pkg::DW'(den_r);
        div_req.b = ga_r;
      end
      default: begin
        div_req.a = ga_r;
        div_req.b = gb_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mnr_pkg::S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zero_r      <= zero_nxt;
    whole_r     <= whole_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    total_r     <= total_nxt;
    w_r         <= w_nxt;
    n_r         <= n_nxt;
    ga_r        <= ga_nxt;
    gb_r        <= gb_nxt;
    nq_r        <= nq_nxt;
    dq_r        <= dq_nxt;
    out_whole_r <= out_whole_nxt;
    out_numer_r <= out_numer_nxt;
    out_denom_r <= out_denom_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    zero_nxt      = zero_r;
    whole_nxt     = whole_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    total_nxt     = total_r;
    w_nxt         = w_r;
    n_nxt         = n_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    nq_nxt        = nq_r;
    dq_nxt        = dq_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    out_whole_nxt = out_whole_r;
    out_numer_nxt = out_numer_r;
    out_denom_nxt = out_denom_r;
    out_zero_nxt  = out_zero_r;
    in_word.ready = 1'b0;

    unique case (state_r)
      mnr_pkg::S_IDLE: begin
        in_word.ready = 1'b1;
        if (in_word.valid) begin
          whole_nxt = in_word.whole_in;
          num_nxt   = in_word.numer_in;
          den_nxt   = in_word.denom_in;
          zero_nxt  = in_word.denom_in == '0;
          state_nxt = (in_word.denom_in == '0) ? mnr_pkg::S_DONE : mnr_pkg::S_MUL;
        end
      end
      mnr_pkg::S_MUL: begin
        total_nxt = mnr_pkg::DW'(prod) + mnr_pkg::DW'(num_r);
        if (!mode_r) begin
          state_nxt = mnr_pkg::S_DIV_W;
        end else begin
          w_nxt     = '0;
          n_nxt     = mnr_pkg::DW'(prod) + mnr_pkg::DW'(num_r);
          ga_nxt    = mnr_pkg::DW'(prod) + mnr_pkg::DW'(num_r);
          gb_nxt    = mnr_pkg::DW'(den_r);
          state_nxt = mnr_pkg::S_GCD;
        end
        go_nxt = 1'b1;
      end
      mnr_pkg::S_DIV_W: begin
        if (div_rsp.done) begin
          w_nxt     = div_rsp.quo;
          n_nxt     = div_rsp.rem;
          ga_nxt    = div_rsp.rem;
          gb_nxt    = mnr_pkg::DW'(den_r);
          go_nxt    = 1'b1;
          state_nxt = mnr_pkg::S_GCD;
        end
      end
      mnr_pkg::S_GCD: begin
        if (div_rsp.done) begin
          ga_nxt = gb_r;
          gb_nxt = div_rsp.rem;
          go_nxt = 1'b1;
          if (div_rsp.rem == '0) begin
            state_nxt = mnr_pkg::S_DIV_N;
          end
        end
      end
      mnr_pkg::S_DIV_N: begin
        if (div_rsp.done) begin
          nq_nxt    = div_rsp.quo;
          go_nxt    = 1'b1;
          state_nxt = mnr_pkg::S_DIV_D;
        end
      end
      mnr_pkg::S_DIV_D: begin
        if (div_rsp.done) begin
          dq_nxt    = mnr_pkg::DENOM_W'(div_rsp.quo);
          state_nxt = mnr_pkg::S_DONE;
        end
      end
      mnr_pkg::S_DONE: begin
        if (!out_valid_r || out_word.ready) begin
          out_valid_nxt = 1'b1;
          out_zero_nxt  = zero_r;
          out_whole_nxt = zero_r ? '0 : mnr_pkg::WHOLE_W'(w_r);
          out_numer_nxt = zero_r ? '0 : mnr_pkg::NUMER_W'(nq_r);
          out_denom_nxt = zero_r ? '0 : dq_r;
          state_nxt = mnr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mnr_pkg::S_IDLE;
      end
    endcase
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.whole_out = out_whole_r;
  assign out_word.numer_out = out_numer_r;
  assign out_word.denom_out = out_denom_r;
  assign out_word.div_zero  = out_zero_r;

endmodule
`default_nettype wire

/* rtl/core/mnr_checker.sv */
`default_nettype none
module mnr_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               in_valid,
  input wire                               in_ready,
  input wire                               out_valid,
  input wire                               out_ready,
  input wire signed [mnr_pkg::WHOLE_W-1:0] whole_out,
  input wire signed [mnr_pkg::NUMER_W-1:0] numer_out,
  input wire signed [mnr_pkg::DENOM_W-1:0] denom_out,
  input wire                               div_zero
);

  // error word carries nothing else
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && div_zero |-> whole_out == '0 && numer_out == '0 && denom_out == '0)
    else $error("div_zero word with nonzero fields");

  // reduced denominator is never zero
  a_denom_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !div_zero |-> denom_out != '0)
    else $error("zero denominator in result word");

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(whole_out) && $stable(numer_out)
      && $stable(denom_out) && $stable(div_zero))
    else $error("stalled result word changed");

endmodule

bind mixed_number_reduce mnr_checker u_mnr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_word.valid),
  .in_ready  (in_word.ready),
  .out_valid (out_word.valid),
  .out_ready (out_word.ready),
  .whole_out (out_word.whole_out),
  .numer_out (out_word.numer_out),
  .denom_out (out_word.denom_out),
  .div_zero  (out_word.div_zero)
);
`default_nettype wire

/* verif/mixed_number_reduce_tb.sv */
`default_nettype none
module mixed_number_reduce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int WORD_LATENCY = 1200;
  localparam int CYCLE_LIMIT  = 6_000_000;

  typedef enum bit {
    MODE_MIXED    = 1'b0,
    MODE_IMPROPER = 1'b1
  } reduce_mode_t;

  typedef struct packed {
    logic signed [mnr_pkg::WHOLE_W-1:0] whole;
    logic signed [mnr_pkg::NUMER_W-1:0] numer;
    logic signed [mnr_pkg::DENOM_W-1:0] denom;
    logic                               div_zero;
  } frac_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mnr_in_if  in_word();
  mnr_out_if out_word();

  mixed_number_reduce u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word.sink),
    .out_word  (out_word.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  reduce_mode_t reduce_mode;
  frac_result_t pending_fractions[$];
  int           mismatch_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  longint       cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint euclid_gcd(longint a, longint b);
    longint r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic frac_result_t reduce_fraction(
      input logic signed [mnr_pkg::IN_WIDTH-1:0] w,
      input logic signed [mnr_pkg::IN_WIDTH-1:0] n,
      input logic signed [mnr_pkg::IN_WIDTH-1:0] d,
      input reduce_mode_t mode);
    frac_result_t res;
    longint       total;
    longint       wq;
    longint       rem;
    longint       g;
    res = '0;
    if (d == 0) begin
      res.div_zero = 1'b1;
      return res;
    end
    total = longint'(w) * longint'(d) + longint'(n);
    if (mode == MODE_MIXED) begin
      wq  = total / longint'(d);
      rem = total % longint'(d);
    end else begin
      wq  = 0;
      rem = total;
    end
    g = euclid_gcd(rem, longint'(d));
    res.whole = wq[mnr_pkg::WHOLE_W-1:0];
    res.numer = mnr_pkg::NUMER_W'(rem / g);
    res.denom = mnr_pkg::DENOM_W'(longint'(d) / g);
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    frac_result_t want;
    if (rst_n && out_word.valid && out_word.ready) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_fractions.pop_front();
        if (out_word.whole_out !== want.whole)
          report_mismatch($sformatf("whole_out %0d, want %0d", out_word.whole_out,
                                    want.whole));
        if (out_word.numer_out !== want.numer)
          report_mismatch($sformatf("numer_out %0d, want %0d", out_word.numer_out,
                                    want.numer));
        if (out_word.denom_out !== want.denom)
          report_mismatch($sformatf("denom_out %0d, want %0d", out_word.denom_out,
                                    want.denom));
        if (out_word.div_zero !== want.div_zero)
          report_mismatch($sformatf("div_zero %0b, want %0b", out_word.div_zero,
                                    want.div_zero));
      end
    end
  end

  always @(negedge clk) begin
    out_word.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_fraction(input logic signed [mnr_pkg::IN_WIDTH-1:0] w,
                               input logic signed [mnr_pkg::IN_WIDTH-1:0] n,
                               input logic signed [mnr_pkg::IN_WIDTH-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_word.valid = 1'b0;
      @(negedge clk);
    end
    in_word.whole_in = w;
    in_word.numer_in = n;
    in_word.denom_in = d;
    in_word.valid    = 1'b1;
    do @(posedge clk); while (!in_word.ready);
    pending_fractions.push_back(reduce_fraction(w, n, d, reduce_mode));
    @(negedge clk);
  endtask

  task automatic park_input();
    in_word.valid = 1'b0;
  endtask

  task automatic wait_drained();
    park_input();
    while (pending_fractions.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_mode(input reduce_mode_t mode);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we      = 1'b0;
    reduce_mode = mode;
  endtask

  task automatic send_random_fraction();
    logic signed [mnr_pkg::IN_WIDTH-1:0] w;
    logic signed [mnr_pkg::IN_WIDTH-1:0] n;
    logic signed [mnr_pkg::IN_WIDTH-1:0] d;
    int                                  kind;
    kind = $urandom_range(99);
    w    = mnr_pkg::IN_WIDTH'($urandom);
    n    = mnr_pkg::IN_WIDTH'($urandom);
    d    = mnr_pkg::IN_WIDTH'($urandom);
    if (kind < 4) begin
      d = '0;
    end else if (kind < 34) begin
      d = mnr_pkg::IN_WIDTH'($urandom_range(12, 1));
      if ($urandom_range(1)) d = -d;
      w = mnr_pkg::IN_WIDTH'($urandom_range(40) - 20);
      n = mnr_pkg::IN_WIDTH'($urandom_range(100) - 50);
    end else if (kind < 44) begin
      n = $urandom_range(1) ? d : -d;
    end else if (kind < 50) begin
      w = '0;
    end
    send_fraction(w, n, d);
  endtask

  task automatic test_directed(input reduce_mode_t mode);
    set_mode(mode);
    send_fraction(16'sd0, 16'sd0, 16'sd1);
    send_fraction(16'sd1, 16'sd1, 16'sd2);
    send_fraction(16'sd2, 16'sd6, 16'sd4);
    send_fraction(-16'sd3, 16'sd1, 16'sd2);
    send_fraction(16'sd3, -16'sd5, 16'sd4);
    send_fraction(16'sd0, 16'sd6, -16'sd4);
    send_fraction(16'sd32767, 16'sd32767, 16'sd32767);
    send_fraction(-16'sd32768, -16'sd32768, -16'sd32768);
    send_fraction(-16'sd32768, 16'sd32767, -16'sd1);
    send_fraction(16'sd5, 16'sd7, 16'sd0);
    send_fraction(16'sd1, 16'sd0, -16'sd32768);
    send_fraction(16'sd0, -16'sd32768, 16'sd32767);
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct);
    reduce_mode_t mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int m = 0; m < 2; m++) begin
      mode = (m == 0) ? MODE_MIXED : MODE_IMPROPER;
      set_mode(mode);
      repeat (82) send_random_fraction();
      wait_drained();
      repeat (83) send_random_fraction();
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 1'b0;
    in_word.valid    = 1'b0;
    in_word.whole_in = '0;
    in_word.numer_in = '0;
    in_word.denom_in = '0;
    out_word.ready   = 1'b0;
    reduce_mode      = MODE_MIXED;
    mismatch_count   = 0;
    send_idle_pct    = 12;
    recv_idle_pct    = 57;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed(MODE_MIXED);
    test_directed(MODE_IMPROPER);
    test_random_phase(12, 57);
    test_random_phase(57, 12);
    test_random_phase(0, 0);

    wait_drained();
    repeat (WORD_LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* mixed_number_reduce.f */
rtl/core/mnr_pkg.sv
rtl/core/mnr_in_if.sv
rtl/core/mnr_out_if.sv
rtl/core/mnr_div.sv
rtl/core/mixed_number_reduce.sv
rtl/core/mnr_checker.sv
verif/mixed_number_reduce_tb.sv
